### src/bary_pkg.sv
// ============================================================================
// Barycentric weights package
// Shared payload types, register map and pipeline latencies.
// ============================================================================
package bary_pkg;

    // Fixed field widths of the payload.
    localparam int FIELD_BITS  = 16;
    localparam int WEIGHT_BITS = 32;

    // Quotient bits produced by the divider, one per stage.
    localparam int QBITS      = 34;
    // Divider: overflow check stage, one stage per quotient bit, round stage.
    localparam int DIV_LAT    = QBITS + 2;
    // Edge differences, products, cross sums.
    localparam int CROSS_LAT  = 3;
    // Cross stages, sign fix-up stage, divider, output register.
    localparam int TOTAL_LAT  = CROSS_LAT + 1 + DIV_LAT + 1;

    // Register indexes.
    localparam logic [2:0] REG_A_X = 3'd0;
    localparam logic [2:0] REG_A_Y = 3'd1;
    localparam logic [2:0] REG_B_X = 3'd2;
    localparam logic [2:0] REG_B_Y = 3'd3;
    localparam logic [2:0] REG_C_X = 3'd4;
    localparam logic [2:0] REG_C_Y = 3'd5;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] point_x;
        logic signed [FIELD_BITS-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_a;
        logic signed [WEIGHT_BITS-1:0] weight_b;
        logic signed [WEIGHT_BITS-1:0] weight_c;
        logic                          degenerate;
    } weights_t;

endpackage

### src/bary_cross.sv
// ============================================================================
// Barycentric cross products
// Three-stage pipeline: edge differences, products, cross sums.
// ============================================================================
module bary_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                        out_valid,
    output logic signed [2*COORD_BITS+2:0] cross_den,
    output logic signed [2*COORD_BITS+2:0] cross_a,
    output logic signed [2*COORD_BITS+2:0] cross_b,
    output logic signed [2*COORD_BITS+2:0] cross_c
);
    import bary_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int SW = 2 * COORD_BITS + 3;

    logic [CROSS_LAT-1:0] valid_reg;

    logic signed [DW-1:0] bax_reg, bay_reg, cax_reg, cay_reg, pax_reg, pay_reg;
    logic signed [DW-1:0] bpx_reg, bpy_reg, cpx_reg, cpy_reg;
    logic signed [PW-1:0] pd0_reg, pd1_reg, pb0_reg, pb1_reg;
    logic signed [PW-1:0] pc0_reg, pc1_reg, pa0_reg, pa1_reg;
    logic signed [SW-1:0] den_reg, na_reg, nb_reg, nc_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CROSS_LAT-2:0], in_valid};
        end
    end

    // Stage 1: edge vectors relative to vertex a and to the point.
    always_ff @(posedge clk)
    begin
        bax_reg <= DW'(bx) - DW'(ax);
        bay_reg <= DW'(by) - DW'(ay);
        cax_reg <= DW'(cx) - DW'(ax);
        cay_reg <= DW'(cy) - DW'(ay);
        pax_reg <= DW'(px) - DW'(ax);
        pay_reg <= DW'(py) - DW'(ay);
        bpx_reg <= DW'(bx) - DW'(px);
        bpy_reg <= DW'(by) - DW'(py);
        cpx_reg <= DW'(cx) - DW'(px);
        cpy_reg <= DW'(cy) - DW'(py);
    end

    // Stage 2: the eight products of the four 2-D cross products.
    always_ff @(posedge clk)
    begin
        pd0_reg <= bax_reg * cay_reg;
        pd1_reg <= bay_reg * cax_reg;
        pb0_reg <= pax_reg * cay_reg;
        pb1_reg <= pay_reg * cax_reg;
        pc0_reg <= bax_reg * pay_reg;
        pc1_reg <= bay_reg * pax_reg;
        pa0_reg <= bpx_reg * cpy_reg;
        pa1_reg <= bpy_reg * cpx_reg;
    end

    // Stage 3: differences of the products.
    always_ff @(posedge clk)
    begin
        den_reg <= SW'(pd0_reg) - SW'(pd1_reg);
        nb_reg  <= SW'(pb0_reg) - SW'(pb1_reg);
        nc_reg  <= SW'(pc0_reg) - SW'(pc1_reg);
        na_reg  <= SW'(pa0_reg) - SW'(pa1_reg);
    end

    assign out_valid = valid_reg[CROSS_LAT-1];
    assign cross_den = den_reg;
    assign cross_a   = na_reg;
    assign cross_b   = nb_reg;
    assign cross_c   = nc_reg;

endmodule

### src/bary_div.sv
// ============================================================================
// Barycentric fixed-point divider
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero) and saturation to 32 bits.
// ============================================================================
module bary_div #(
    parameter int MAG_BITS  = 35,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic [MAG_BITS-1:0] mag,
    input  logic [MAG_BITS-1:0] den,
    input  logic                neg,
    output logic signed [31:0]  weight
);
    import bary_pkg::*;

    localparam int XW = MAG_BITS + FRAC_BITS + 1 + QBITS;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [33:0] LIM   = 34'h0_8000_0000;

    logic [XW-1:0]       rem_reg [0:QBITS-1];
    logic [QBITS-1:0]    q_reg   [0:QBITS];
    logic [MAG_BITS-1:0] d_reg   [0:QBITS-1];
    logic [QBITS:0]      neg_reg;
    logic [QBITS:0]      ovf_reg;
    logic [XW-1:0]       num_ext;
    logic [XW-1:0]       den_top;
    logic [XW-1:0]       dsh     [0:QBITS-1];
    logic [QBITS-1:0]    ge;
    logic [QBITS:0]      sum;
    logic [33:0]         tot;
    logic [31:0]         weight_next;
    logic [31:0]         weight_reg;

    // Overflow when the quotient would need more than QBITS bits.
    assign num_ext = XW'(mag) << (FRAC_BITS + 1);
    assign den_top = XW'(den) << QBITS;

    // Trial subtraction of the shifted divisor in each stage.
    always_comb
    begin
        for (int k = 0; k < QBITS; k++)
        begin
            dsh[k] = XW'(d_reg[k]) << (QBITS - 1 - k);
            ge[k]  = (rem_reg[k] >= dsh[k]);
        end
    end

    // Entry stage and one quotient bit per stage after it.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_ext;
        q_reg[0]   <= '0;
        d_reg[0]   <= den;
        neg_reg[0] <= neg;
        ovf_reg[0] <= (num_ext >= den_top);
        for (int k = 0; k < QBITS; k++)
        begin
            if (k < QBITS - 1)
            begin
                rem_reg[k+1] <= ge[k] ? (rem_reg[k] - dsh[k]) : rem_reg[k];
                d_reg[k+1]   <= d_reg[k];
            end
            q_reg[k+1]   <= {q_reg[k][QBITS-2:0], ge[k]};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    // The quotient carries one extra fraction bit; adding it rounds.
    assign sum = {1'b0, q_reg[QBITS]} + (QBITS+1)'(1);
    assign tot = sum[QBITS:1];

    always_comb
    begin
        if (ovf_reg[QBITS])
        begin
            weight_next = neg_reg[QBITS] ? W_MIN : W_MAX;
        end
        else if (neg_reg[QBITS])
        begin
            weight_next = (tot >= LIM) ? W_MIN : (32'd0 - tot[31:0]);
        end
        else
        begin
            weight_next = (tot >= LIM) ? W_MAX : tot[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign weight = weight_reg;

endmodule

### src/triangle_barycentric_weights_top.sv
// ============================================================================
// Triangle barycentric weights
// Weights of a query point with respect to a triangle held in registers.
// ============================================================================
// Usage:
// The six vertex coordinates are written over the APB port, registers 0..5
// at byte addresses 0, 4, ..., 20 (a.x, a.y, b.x, b.y, c.x, c.y). paddr[1:0]
// is ignored, writes at 24..31 are dropped; reads return the stored coordinate.
// A point transfer happens on a clock edge with start high and busy low.
// busy is always low: the pipeline takes a new point in every cycle.
// Each point produces exactly one result, presented on result for a single
// cycle with done high. After its transfer, a point passes through three
// cross-product stages, a sign stage, the divider's check stage, 34 stages
// that resolve one quotient bit per stage, the divider's rounding stage and
// the output register.
// Throughput is one result per cycle. The receiver cannot stall done.
// A degenerate triangle (zero area) gives zero weights and degenerate = 1.
// Reset clears the vertices to zero and empties the pipeline; any point in
// flight at reset is dropped.
// ============================================================================
module triangle_barycentric_weights_top #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bary_pkg::point_t  point,
    output logic              done,
    output bary_pkg::weights_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bary_pkg::*;

    localparam int SW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] px, py;
    logic [2:0]                   reg_idx;
    logic                         wr_en;

    logic                  cr_valid;
    logic signed [SW-1:0]  cr_den, cr_a, cr_b, cr_c;

    logic                  prep_valid_reg;
    logic                  prep_zero_reg;
    logic [SW-1:0]         den_mag_reg;
    logic [SW-1:0]         mag_a_reg, mag_b_reg, mag_c_reg;
    logic                  neg_a_reg, neg_b_reg, neg_c_reg;

    logic [DIV_LAT-1:0]    valid_pipe_reg;
    logic [DIV_LAT-1:0]    zero_pipe_reg;
    logic signed [31:0]    w_a, w_b, w_c;

    logic                  done_reg;
    weights_t              result_reg;
    weights_t              result_next;

    // Configuration port: a write lands in the access phase.
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_A_X: ax_reg <= pwdata[COORD_BITS-1:0];
                REG_A_Y: ay_reg <= pwdata[COORD_BITS-1:0];
                REG_B_X: bx_reg <= pwdata[COORD_BITS-1:0];
                REG_B_Y: by_reg <= pwdata[COORD_BITS-1:0];
                REG_C_X: cx_reg <= pwdata[COORD_BITS-1:0];
                REG_C_Y: cy_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (reg_idx)
            REG_A_X: prdata = 32'(unsigned'(ax_reg));
            REG_A_Y: prdata = 32'(unsigned'(ay_reg));
            REG_B_X: prdata = 32'(unsigned'(bx_reg));
            REG_B_Y: prdata = 32'(unsigned'(by_reg));
            REG_C_X: prdata = 32'(unsigned'(cx_reg));
            REG_C_Y: prdata = 32'(unsigned'(cy_reg));
            default: prdata = '0;
        endcase
    end

    // Point coordinates: a wider field is cut to its low bits, a narrower field zero-extends.
    generate
        if (COORD_BITS <= FIELD_BITS)
        begin : g_narrow
            assign px = point.point_x[COORD_BITS-1:0];
            assign py = point.point_y[COORD_BITS-1:0];
        end
        else
        begin : g_wide
            assign px = {{(COORD_BITS-FIELD_BITS){1'b0}}, point.point_x};
            assign py = {{(COORD_BITS-FIELD_BITS){1'b0}}, point.point_y};
        end
    endgenerate

    bary_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .bx        (bx_reg),
        .by        (by_reg),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .px        (px),
        .py        (py),
        .out_valid (cr_valid),
        .cross_den (cr_den),
        .cross_a   (cr_a),
        .cross_b   (cr_b),
        .cross_c   (cr_c)
    );

    // Sign stage: magnitudes and result signs for the dividers.
    always_ff @(posedge clk)
    begin
        prep_zero_reg <= (cr_den == '0);
        den_mag_reg   <= cr_den[SW-1] ? (SW'(0) - cr_den) : cr_den;
        mag_a_reg     <= cr_a[SW-1] ? (SW'(0) - cr_a) : cr_a;
        mag_b_reg     <= cr_b[SW-1] ? (SW'(0) - cr_b) : cr_b;
        mag_c_reg     <= cr_c[SW-1] ? (SW'(0) - cr_c) : cr_c;
        neg_a_reg     <= cr_a[SW-1] ^ cr_den[SW-1];
        neg_b_reg     <= cr_b[SW-1] ^ cr_den[SW-1];
        neg_c_reg     <= cr_c[SW-1] ^ cr_den[SW-1];
    end

    bary_div #(.MAG_BITS (SW), .FRAC_BITS (WEIGHT_FRAC_BITS)) u_div_a (
        .clk (clk), .mag (mag_a_reg), .den (den_mag_reg), .neg (neg_a_reg),
        .weight (w_a)
    );

    bary_div #(.MAG_BITS (SW), .FRAC_BITS (WEIGHT_FRAC_BITS)) u_div_b (
        .clk (clk), .mag (mag_b_reg), .den (den_mag_reg), .neg (neg_b_reg),
        .weight (w_b)
    );

    bary_div #(.MAG_BITS (SW), .FRAC_BITS (WEIGHT_FRAC_BITS)) u_div_c (
        .clk (clk), .mag (mag_c_reg), .den (den_mag_reg), .neg (neg_c_reg),
        .weight (w_c)
    );

    // Valid bits alongside the sign stage and the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            valid_pipe_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= cr_valid;
            valid_pipe_reg <= {valid_pipe_reg[DIV_LAT-2:0], prep_valid_reg};
            done_reg       <= valid_pipe_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        zero_pipe_reg <= {zero_pipe_reg[DIV_LAT-2:0], prep_zero_reg};
    end

    // Output register: a degenerate triangle forces zero weights.
    always_comb
    begin
        result_next.degenerate = zero_pipe_reg[DIV_LAT-1];
        if (zero_pipe_reg[DIV_LAT-1])
        begin
            result_next.weight_a = '0;
            result_next.weight_b = '0;
            result_next.weight_c = '0;
        end
        else
        begin
            result_next.weight_a = w_a;
            result_next.weight_b = w_b;
            result_next.weight_c = w_c;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every transfer yields a result after the full latency.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("accepted point produced no result");

    // No result without a matching transfer.
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without a matching point");

    // A degenerate result carries zero weights.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |->
            (result.weight_a == '0 && result.weight_b == '0 && result.weight_c == '0))
        else $error("degenerate result with nonzero weights");

endmodule
